// ===== rtl/magic_header_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Magic header frame parser assertion macros
// Shorthand for the concurrent checks of the frame parser checker.
// ----------------------------------------------------------------------------
`ifndef MAGIC_HEADER_FRAME_PARSER_MACROS_SVH
`define MAGIC_HEADER_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHFP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mhfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Magic header frame parser package
// Item types, frame phases, status codes and framing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhfp_pkg;

   // Magic sequence and fixed header values.
   localparam logic [7:0]  MAGIC_0       = 8'h0A;
   localparam logic [7:0]  MAGIC_1       = 8'h1B;
   localparam logic [7:0]  MAGIC_2       = 8'h2C;
   localparam logic [7:0]  MAGIC_3       = 8'h3D;
   localparam logic [23:0] MAGIC_PREFIX  = {MAGIC_0, MAGIC_1, MAGIC_2};
   localparam logic [7:0]  MAGIC_SUM     = 8'(MAGIC_0 + MAGIC_1 + MAGIC_2 + MAGIC_3);
   localparam logic [7:0]  VERSION_VALUE = 8'h00;

   // Header plus checksum bytes around the payload, and the length ceiling.
   localparam logic [9:0]  FRAME_OVERHEAD = 10'd11;
   localparam logic [8:0]  FRAME_LEN_MAX  = 9'h1FF;
   localparam logic [15:0] LENGTH_MIN     = 16'd2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_BIG_ENDIAN = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_LIMIT     = 1'd1;

   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_STATUS  = 1'b1;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_VER   = 4'd1,
      PH_SEQ   = 4'd2,
      PH_LEN_A = 4'd3,
      PH_LEN_B = 4'd4,
      PH_CMD_A = 4'd5,
      PH_CMD_B = 4'd6,
      PH_PAY   = 4'd7,
      PH_SUM   = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_LINK     = 3'd1,
      ST_VERSION      = 3'd2,
      ST_LENGTH_SHORT = 3'd3,
      ST_LENGTH_LONG  = 3'd4,
      ST_CHECKSUM     = 3'd5,
      ST_DUPLICATE    = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [2:0] link_id;
   } req_item_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_sn;
      logic [15:0] frame_cmd;
      logic [8:0] payload_length;
      logic [8:0] frame_length;
      status_type status;
   } rsp_item_type;

endpackage

// ===== rtl/magic_header_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Magic header frame parser
// Finds framed messages in a byte stream, checks them and emits their
// payload bytes followed by one status item per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stream byte and its link number per item. rsp_* carries
//   payload byte items and one end-of-frame status item per frame. Both
//   channels transfer an item when valid is high and stall is low.
//   csr_* writes the byte order and payload limit registers; the user must
//   write them only while idle, as the block itself does not enforce it.
// Throughput:
//   One byte is accepted every cycle while req_stall is low. The rate is set
//   by the per-byte phase update, a single pass of compare, add and select
//   logic between the frame state registers.
// Stall:
//   Results go to an output register backed by one skid entry. A byte is
//   still accepted while the output register waits; req_stall rises only
//   while the skid entry is occupied.
// Reset:
//   Synchronous, active high. Clears the hunt state, the per-link sequence
//   memory valid bits and the output, and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module magic_header_frame_parser #(
   parameter int PAYLOAD_MAX = 256,
   parameter int NUM_LINKS   = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mhfp_pkg::req_item_type               req_data,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mhfp_pkg::rsp_item_type               rsp_data,

   input  logic                                 csr_we,
   input  logic [mhfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mhfp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Link numbers are three bits wide and link 0 is rejected, so at most seven links can be used.
   localparam int LINK_SLOTS = (NUM_LINKS < 8) ? NUM_LINKS : 8;
   localparam int LINK_IDX_W = $clog2(LINK_SLOTS);

   // Configuration registers.
   logic       big_endian_ff;
   logic [8:0] limit_ff;

   // Frame state.
   mhfp_pkg::phase_type phase_ff, phase_in;
   logic [23:0] window_ff, window_in;
   logic [8:0]  index_ff, index_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [8:0]  pay_len_ff, pay_len_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  sum_ff, sum_in;
   logic [2:0]  link_ff, link_in;

   logic [7:0] last_seq_ff [LINK_SLOTS];
   logic       seen_ff     [LINK_SLOTS];

   // Output register and skid entry.
   logic                   out_valid_ff;
   logic                   skid_valid_ff;
   mhfp_pkg::rsp_item_type out_data_ff;
   mhfp_pkg::rsp_item_type skid_data_ff;

   logic                   accept;
   logic                   out_fire;
   logic                   res_valid;
   logic                   res_kind;
   mhfp_pkg::status_type   res_status;
   mhfp_pkg::rsp_item_type res_item;
   logic                   seq_update;

   logic [7:0]            rx;
   logic [7:0]            sum_add;
   logic [15:0]           word;
   logic [15:0]           word_m2;
   logic [8:0]            applied_limit;
   logic [8:0]            index_next;
   logic [9:0]            frame_len_sum;
   logic [LINK_IDX_W-1:0] li;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign out_fire  = out_valid_ff && !rsp_stall;

   assign rx            = req_data.rx_byte;
   assign sum_add       = sum_ff + rx;
   assign li            = link_ff[LINK_IDX_W-1:0];
   assign index_next    = index_ff + 9'd1;
   assign applied_limit = (int'(limit_ff) > PAYLOAD_MAX) ? 9'(PAYLOAD_MAX) : limit_ff;
   assign frame_len_sum = {1'b0, pay_len_ff} + mhfp_pkg::FRAME_OVERHEAD;

   // Length and command words in the configured byte order.
   always_comb begin
      if (phase_ff == mhfp_pkg::PH_CMD_B) begin
         word = big_endian_ff ? {cmd_ff[7:0], rx} : {rx, cmd_ff[7:0]};
      end else begin
         word = big_endian_ff ? {len_lo_ff, rx} : {rx, len_lo_ff};
      end
   end
   assign word_m2 = word - mhfp_pkg::LENGTH_MIN;

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      index_in   = index_ff;
      len_lo_in  = len_lo_ff;
      pay_len_in = pay_len_ff;
      seq_in     = seq_ff;
      cmd_in     = cmd_ff;
      sum_in     = sum_ff;
      link_in    = link_ff;
      res_valid  = 1'b0;
      res_kind   = mhfp_pkg::ITEM_PAYLOAD;
      res_status = mhfp_pkg::ST_OK;
      seq_update = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            mhfp_pkg::PH_VER: begin
               sum_in = sum_add;
               if (rx != mhfp_pkg::VERSION_VALUE) begin
                  res_valid  = 1'b1;
                  res_kind   = mhfp_pkg::ITEM_STATUS;
                  res_status = mhfp_pkg::ST_VERSION;
               end else begin
                  phase_in = mhfp_pkg::PH_SEQ;
               end
            end
            mhfp_pkg::PH_SEQ: begin
               sum_in   = sum_add;
               seq_in   = rx;
               phase_in = mhfp_pkg::PH_LEN_A;
            end
            mhfp_pkg::PH_LEN_A: begin
               sum_in    = sum_add;
               len_lo_in = rx;
               phase_in  = mhfp_pkg::PH_LEN_B;
            end
            mhfp_pkg::PH_LEN_B: begin
               sum_in = sum_add;
               if (word < mhfp_pkg::LENGTH_MIN) begin
                  res_valid  = 1'b1;
                  res_kind   = mhfp_pkg::ITEM_STATUS;
                  res_status = mhfp_pkg::ST_LENGTH_SHORT;
               end else if (word_m2 > {7'd0, applied_limit}) begin
                  res_valid  = 1'b1;
                  res_kind   = mhfp_pkg::ITEM_STATUS;
                  res_status = mhfp_pkg::ST_LENGTH_LONG;
               end else begin
                  pay_len_in = word_m2[8:0];
                  phase_in   = mhfp_pkg::PH_CMD_A;
               end
            end
            mhfp_pkg::PH_CMD_A: begin
               sum_in   = sum_add;
               cmd_in   = {8'h00, rx};
               phase_in = mhfp_pkg::PH_CMD_B;
            end
            mhfp_pkg::PH_CMD_B: begin
               sum_in   = sum_add;
               cmd_in   = word;
               index_in = '0;
               phase_in = (pay_len_ff == '0) ? mhfp_pkg::PH_SUM : mhfp_pkg::PH_PAY;
            end
            mhfp_pkg::PH_PAY: begin
               sum_in    = sum_add;
               index_in  = index_next;
               res_valid = 1'b1;
               if (index_next >= pay_len_ff) begin
                  phase_in = mhfp_pkg::PH_SUM;
               end
            end
            mhfp_pkg::PH_SUM: begin
               res_valid = 1'b1;
               res_kind  = mhfp_pkg::ITEM_STATUS;
               if (rx != sum_ff) begin
                  res_status = mhfp_pkg::ST_CHECKSUM;
               end else if (seq_ff != '0 && seen_ff[li] && last_seq_ff[li] == seq_ff) begin
                  res_status = mhfp_pkg::ST_DUPLICATE;
               end else begin
                  seq_update = (seq_ff != '0);
               end
            end
            default: begin
               // Hunting; unused phase codes fall back to it as well.
               phase_in = mhfp_pkg::PH_HUNT;
               if (window_ff == mhfp_pkg::MAGIC_PREFIX && rx == mhfp_pkg::MAGIC_3) begin
                  window_in  = '0;
                  seq_in     = '0;
                  cmd_in     = '0;
                  len_lo_in  = '0;
                  index_in   = '0;
                  pay_len_in = '0;
                  sum_in     = mhfp_pkg::MAGIC_SUM;
                  link_in    = req_data.link_id;
                  if (req_data.link_id == '0 || int'(req_data.link_id) >= NUM_LINKS) begin
                     link_in    = '0;
                     res_valid  = 1'b1;
                     res_kind   = mhfp_pkg::ITEM_STATUS;
                     res_status = mhfp_pkg::ST_BAD_LINK;
                  end else begin
                     phase_in = mhfp_pkg::PH_VER;
                  end
               end else begin
                  window_in = {window_ff[15:0], rx};
               end
            end
         endcase

         // Every status item ends the frame and restarts the magic search.
         if (res_valid && res_kind == mhfp_pkg::ITEM_STATUS) begin
            phase_in  = mhfp_pkg::PH_HUNT;
            window_in = '0;
         end
      end
   end

   always_comb begin
      res_item.item_kind      = res_kind;
      res_item.payload_byte   = (res_kind == mhfp_pkg::ITEM_PAYLOAD) ? rx : 8'h00;
      res_item.frame_sn       = seq_in;
      res_item.frame_cmd      = cmd_in;
      res_item.payload_length = pay_len_in;
      res_item.status         = res_status;
      res_item.frame_length   = '0;
      if (res_kind == mhfp_pkg::ITEM_STATUS && res_status == mhfp_pkg::ST_OK) begin
         res_item.frame_length = (frame_len_sum > {1'b0, mhfp_pkg::FRAME_LEN_MAX}) ?
                                 mhfp_pkg::FRAME_LEN_MAX : frame_len_sum[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b1;
         limit_ff      <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            mhfp_pkg::CSR_LENGTH_BIG_ENDIAN: big_endian_ff <= csr_wdata[0];
            mhfp_pkg::CSR_PAYLOAD_LIMIT:     limit_ff      <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mhfp_pkg::PH_HUNT;
         window_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff   <= index_in;
      len_lo_ff  <= len_lo_in;
      pay_len_ff <= pay_len_in;
      seq_ff     <= seq_in;
      cmd_ff     <= cmd_in;
      sum_ff     <= sum_in;
      link_ff    <= link_in;
   end

   // Per-link memory of the last accepted nonzero sequence number.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINK_SLOTS; i++) begin
            seen_ff[i] <= 1'b0;
         end
      end else if (seq_update) begin
         seen_ff[li] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_update) begin
         last_seq_ff[li] <= seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_fire) begin
            out_data_ff  <= res_item;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= res_item;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

// ===== rtl/mhfp_checker.sv =====
// ----------------------------------------------------------------------------
// Magic header frame parser checker
// Port-level checks on result items and flow control of the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "magic_header_frame_parser_macros.svh"

module mhfp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mhfp_pkg::rsp_item_type rsp_data
);

   // Payload items carry no frame length and an ok status.
   `MHFP_ASSERT_SAME(a_payload_clean, rsp_valid && rsp_data.item_kind == mhfp_pkg::ITEM_PAYLOAD, rsp_data.frame_length == '0 && rsp_data.status == mhfp_pkg::ST_OK, "payload item carries status fields")

   // A good frame reports its total length, saturated at the field maximum.
   `MHFP_ASSERT_SAME(a_ok_length, rsp_valid && rsp_data.item_kind == mhfp_pkg::ITEM_STATUS && rsp_data.status == mhfp_pkg::ST_OK, rsp_data.frame_length == ((rsp_data.payload_length > 9'd500) ? 9'd511 : rsp_data.payload_length + 9'd11), "ok status has wrong frame length")

   // Frames rejected before the length word is accepted report no length.
   `MHFP_ASSERT_SAME(a_early_reject, rsp_valid && rsp_data.item_kind == mhfp_pkg::ITEM_STATUS && (rsp_data.status == mhfp_pkg::ST_BAD_LINK || rsp_data.status == mhfp_pkg::ST_VERSION || rsp_data.status == mhfp_pkg::ST_LENGTH_SHORT || rsp_data.status == mhfp_pkg::ST_LENGTH_LONG), rsp_data.payload_length == '0 && rsp_data.frame_length == '0, "early reject carries a length")

   // The input only stalls while a result is waiting at the output.
   `MHFP_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid, "input stalled with empty output")

   // A stalled result item is held unchanged.
   `MHFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result item changed")

endmodule

bind magic_header_frame_parser mhfp_checker u_mhfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
